// ===== src/gesture_press_tap_qualifier_top_defines.svh =====
// Assertion macros for the press and tap qualifier.
`ifndef GESTURE_PRESS_TAP_QUALIFIER_TOP_DEFINES_SVH
`define GESTURE_PRESS_TAP_QUALIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define GPTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define GPTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GPTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define GPTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== src/gptq_pkg.sv =====
// Shared types and constants of the press and tap qualifier.
`timescale 1ns / 1ps
package gptq_pkg;

  localparam int StrengthW = 16;
  localparam int StampW    = 32;
  localparam int TapW      = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [StrengthW-1:0] FullStrength = 16'h8000;
  localparam logic [TapW-1:0]      TapMax       = 8'hFF;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegReleaseThr  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTouchThr    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinTapTime  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxTapTime  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMinDownTime = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinTapCount = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMinRelTime  = 3'd6;

  // Register reset values
  localparam logic [15:0] RstReleaseThr  = 16'd29491;
  localparam logic [15:0] RstTouchThr    = 16'd16384;
  localparam logic [15:0] RstMinTapTime  = 16'd0;
  localparam logic [15:0] RstMaxTapTime  = 16'd300;
  localparam logic [15:0] RstMinDownTime = 16'd0;
  localparam logic [7:0]  RstMinTapCount = 8'd1;
  localparam logic [15:0] RstMinRelTime  = 16'd0;

  typedef struct packed {
    logic [15:0] release_threshold;
    logic [15:0] touch_threshold;
    logic [15:0] min_tap_time_ms;
    logic [15:0] max_tap_time_ms;
    logic [15:0] min_down_time_ms;
    logic [7:0]  min_tap_count;
    logic [15:0] min_release_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [TapW-1:0]      taps;
    logic                 touched;
    logic                 release_edge;
    logic                 press_edge;
    logic                 pressed;
    logic [StrengthW-1:0] strength_echo;
  } res_t;

endpackage

// ===== src/gesture_press_tap_qualifier_top.sv =====
// Top level of the gesture press and tap qualifier.
// Usage:
//   Frames enter on the s_axis channel: strength and a millisecond timestamp.
//   Each frame yields exactly one result on the m_axis channel: the strength
//   passed through, the confirmed-down flag, press and release edges, the
//   touch flag and the saturating tap count.
//   Thresholds and timings are set through the cfg_we/cfg_index/cfg_wdata
//   write port; write them only while no frame is in flight.
// Path and throughput:
//   A frame taken into the input register is qualified by the next-state
//   logic of the core and then lands in the output register, from which
//   the result is offered on m_axis. One frame per cycle is sustained while
//   m_axis_tready stays high; the per-frame state update in the core sets
//   that figure, as each frame needs the state the previous one left.
// Reset:
//   rst (synchronous, active high) empties both registers, clears the press
//   state and tap count, and loads the register defaults.
// Stall:
//   When m_axis_tready is low the result holds in the output register; the
//   input register still takes one more frame, and s_axis_tready drops only
//   once both registers are full.
`timescale 1ns / 1ps
`include "gesture_press_tap_qualifier_top_defines.svh"
module gesture_press_tap_qualifier_top
  import gptq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  // frame input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // strength[15:0], now_ms[47:16]
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // strength_echo[15:0], pressed[16], press_edge[17], release_edge[18],
  // touched[19], taps[27:20], zero fill[31:28]
  output logic [31:0]         m_axis_tdata
);

  cfg_t cfg;
  res_t res;
  res_t out_res;

  logic                 in_valid;
  logic [StrengthW-1:0] in_strength;
  logic [StampW-1:0]    in_now;
  logic                 out_valid;
  logic                 out_free;
  logic                 adv;

  gptq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Output register can take a result when empty or being drained.
  assign out_free      = !out_valid || m_axis_tready;
  // Advance the frame held in the input register into the output register.
  assign adv           = in_valid && out_free;
  assign s_axis_tready = !in_valid || adv;

  gptq_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (adv),
    .strength (in_strength),
    .now_ms   (in_now),
    .res      (res)
  );

  // Control: valid flags of the two registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_strength <= s_axis_tdata[15:0];
      in_now      <= s_axis_tdata[47:16];
    end
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_res.taps, out_res.touched, out_res.release_edge,
                          out_res.press_edge, out_res.pressed, out_res.strength_echo};

  // A press edge is only ever shown on a confirmed-down result.
  `GPTQ_ASSERT_NOW(a_press_edge_down, clk, rst, out_valid && out_res.press_edge,
    out_res.pressed, "press edge without confirmed press")
  // A release edge never comes with the press still confirmed.
  `GPTQ_ASSERT_NOW(a_release_edge_up, clk, rst, out_valid && out_res.release_edge,
    !out_res.pressed, "release edge while still pressed")
  // A stalled frame in the input register must not be lost.
  `GPTQ_ASSERT_NEXT(a_hold_frame, clk, rst, in_valid && !out_free, in_valid,
    "input frame dropped during stall")
  // Output register only fills from a held frame.
  `GPTQ_ASSERT_NEXT(a_out_fill, clk, rst, !out_valid && !in_valid, !out_valid,
    "result appeared without a frame")

endmodule

// ===== src/gptq_cfg.sv =====
// Configuration register file of the press and tap qualifier.
`timescale 1ns / 1ps
module gptq_cfg
  import gptq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.release_threshold   <= RstReleaseThr;
      regs.touch_threshold     <= RstTouchThr;
      regs.min_tap_time_ms     <= RstMinTapTime;
      regs.max_tap_time_ms     <= RstMaxTapTime;
      regs.min_down_time_ms    <= RstMinDownTime;
      regs.min_tap_count       <= RstMinTapCount;
      regs.min_release_time_ms <= RstMinRelTime;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegReleaseThr:  regs.release_threshold   <= cfg_wdata;
        RegTouchThr:    regs.touch_threshold     <= cfg_wdata;
        RegMinTapTime:  regs.min_tap_time_ms     <= cfg_wdata;
        RegMaxTapTime:  regs.max_tap_time_ms     <= cfg_wdata;
        RegMinDownTime: regs.min_down_time_ms    <= cfg_wdata;
        RegMinTapCount: regs.min_tap_count       <= cfg_wdata[7:0];
        RegMinRelTime:  regs.min_release_time_ms <= cfg_wdata;
        default: ; // index beyond the list: drop the write
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== src/gptq_core.sv =====
// Press/release qualifier state and its per-frame next-state logic.
`timescale 1ns / 1ps
module gptq_core
  import gptq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 step,
  input  logic [StrengthW-1:0] strength,
  input  logic [StampW-1:0]    now_ms,
  output res_t                 res
);

  logic            is_pressed, is_pressed_next;
  logic            press_edge_reg, press_edge_reg_next;
  logic            release_edge_reg, release_edge_reg_next;
  logic            pending_down, pending_down_next;
  logic            pending_up, pending_up_next;
  logic [TapW-1:0] tap_counter, tap_counter_next;
  logic [StampW-1:0] press_stamp, press_stamp_next;
  logic [StampW-1:0] release_stamp, release_stamp_next;

  logic            trig_full, hold_full, starting;
  logic [StampW-1:0] tap_gap, down_gap, up_gap;

  assign trig_full = (strength >= FullStrength);
  assign hold_full = trig_full || (strength >= cfg.release_threshold);
  assign starting  = !pending_down && !is_pressed;
  assign tap_gap   = now_ms - press_stamp;
  // a press that starts on this frame restamps to now, so its duration is zero
  assign down_gap  = starting ? '0 : (now_ms - press_stamp);
  // a release timer that starts on this frame restamps to now as well
  assign up_gap    = pending_up ? (now_ms - release_stamp) : '0;

  always_comb begin
    is_pressed_next       = is_pressed;
    press_edge_reg_next   = press_edge_reg;
    release_edge_reg_next = release_edge_reg;
    pending_down_next     = pending_down;
    pending_up_next       = pending_up;
    tap_counter_next      = tap_counter;
    press_stamp_next      = press_stamp;
    release_stamp_next    = release_stamp;

    if (trig_full || (hold_full && is_pressed)) begin
      pending_up_next = 1'b0;
      if (starting) begin
        if ((tap_gap < {16'd0, cfg.max_tap_time_ms}) &&
            (tap_gap > {16'd0, cfg.min_tap_time_ms})) begin
          if (tap_counter != TapMax) begin
            tap_counter_next = tap_counter + TapW'(1);
          end
        end else begin
          tap_counter_next = TapW'(1);
        end
        pending_down_next = 1'b1;
        press_stamp_next  = now_ms;
      end
      if ((down_gap > {16'd0, cfg.min_down_time_ms}) &&
          (tap_counter_next >= cfg.min_tap_count)) begin
        pending_down_next     = 1'b0;
        press_edge_reg_next   = !is_pressed;
        is_pressed_next       = 1'b1;
        release_edge_reg_next = 1'b0;
      end
    end else begin
      if (is_pressed || pending_down) begin
        if (!pending_up) begin
          pending_up_next    = is_pressed;
          release_stamp_next = now_ms;
        end
        if (up_gap > {16'd0, cfg.min_release_time_ms}) begin
          pending_up_next       = 1'b0;
          release_edge_reg_next = is_pressed;
          if (is_pressed) begin
            tap_counter_next = '0;
          end
          press_edge_reg_next = 1'b0;
          is_pressed_next     = 1'b0;
        end
      end else begin
        // idle frame: drop every flag
        pending_up_next       = 1'b0;
        release_edge_reg_next = 1'b0;
        press_edge_reg_next   = 1'b0;
        is_pressed_next       = 1'b0;
      end
      pending_down_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_pressed       <= 1'b0;
      press_edge_reg   <= 1'b0;
      release_edge_reg <= 1'b0;
      pending_down     <= 1'b0;
      pending_up       <= 1'b0;
      tap_counter      <= '0;
      press_stamp      <= '0;
      release_stamp    <= '0;
    end else if (step) begin
      is_pressed       <= is_pressed_next;
      press_edge_reg   <= press_edge_reg_next;
      release_edge_reg <= release_edge_reg_next;
      pending_down     <= pending_down_next;
      pending_up       <= pending_up_next;
      tap_counter      <= tap_counter_next;
      press_stamp      <= press_stamp_next;
      release_stamp    <= release_stamp_next;
    end
  end

  assign res.strength_echo = strength;
  assign res.pressed       = is_pressed_next;
  assign res.press_edge    = press_edge_reg_next;
  assign res.release_edge  = release_edge_reg_next;
  assign res.touched       = (strength > cfg.touch_threshold) || is_pressed_next;
  assign res.taps          = tap_counter_next;

endmodule
